[hw/rtl/cwr_pkg.sv]
// shared types and constants for the cartridge window read side effects unit
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package cwr_pkg;

  localparam int unsigned WINDOW_BYTES = 65536;
  localparam int unsigned OFF_W        = $clog2(WINDOW_BYTES);

  localparam logic [OFF_W-1:0] STATUS_ADDR  = OFF_W'(32512);
  localparam logic [OFF_W-1:0] READY_ADDR   = OFF_W'(30720);
  localparam logic [OFF_W-1:0] STROBE_ADDR  = OFF_W'(32513);
  localparam logic [OFF_W-1:0] MAILBOX_BASE = OFF_W'(28672);

  localparam logic [7:0] KERNEL_READY_MASK = 8'd1;

  localparam int unsigned PAGE_SHIFT = 8;
  localparam int unsigned PORT_COUNT = 8;
  localparam logic [OFF_W:0] MB_LO = {1'b0, MAILBOX_BASE};
  localparam logic [OFF_W:0] MB_HI = MB_LO + (OFF_W+1)'(PORT_COUNT << PAGE_SHIFT);

  localparam logic [2:0] LAST_PORT = 3'd7;
  localparam logic [3:0] NO_PORT   = 4'd8;

  typedef enum logic [2:0] {
    CMD_READ      = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_SET_READY = 3'd2,
    CMD_BUMP      = 3'd3,
    CMD_CLEAR     = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [OFF_W-1:0] off;
    logic [7:0]       data;
    logic             more;
  } item_t;

  typedef struct packed {
    logic [3:0]  last_port;
    logic [7:0]  frame_ready_now;
    logic [7:0]  status_now;
    logic [31:0] frames_staged;
    logic [31:0] frames_consumed;
    logic        frame_consumed_pulse;
    logic        advance_taken;
    logic [7:0]  read_data;
  } result_t;

  typedef struct packed {
    logic             en;
    logic [OFF_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

endpackage

[hw/rtl/cwr_window_store.sv]
// 64 KB window memory with registered read, same-cycle write forwarding
// and the zeroing sweep after reset; uses cwr_pkg
`timescale 1ns / 1ps

module cwr_window_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [cwr_pkg::OFF_W-1:0] rd_addr,
  input  cwr_pkg::wr_req_t         wr_req,
  output logic [7:0]               rd_data,
  output logic                     clear_busy
);
  import cwr_pkg::*;

  logic [7:0] mem [WINDOW_BYTES];

  logic             clr_busy_r;
  logic [OFF_W-1:0] clr_addr_r;
  logic [7:0]       rd_q_r;
  logic             fwd_hit_r;
  logic [7:0]       fwd_data_r;

  logic             we;
  logic [OFF_W-1:0] waddr;
  logic [7:0]       wdata;

  // sweep owns the write port until every entry is zero
  always_comb begin
    we    = clr_busy_r | wr_req.en;
    waddr = clr_busy_r ? clr_addr_r : wr_req.addr;
    wdata = clr_busy_r ? 8'd0 : wr_req.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + OFF_W'(1);
      if (clr_addr_r == {OFF_W{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_hit_r  <= we && (waddr == rd_addr);
      fwd_data_r <= wdata;
    end
  end

  assign rd_data    = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign clear_busy = clr_busy_r;

endmodule

[hw/rtl/cwr_side_effects.sv]
// address decode, side-effect registers and window write-back request
// uses cwr_pkg; fed by the stage register and the window read data
`timescale 1ns / 1ps

module cwr_side_effects (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  cwr_pkg::item_t    item,
  input  logic [7:0]        mem_data,
  output cwr_pkg::result_t  result,
  output cwr_pkg::wr_req_t  wr_req
);
  import cwr_pkg::*;

  logic [7:0]  status_r, status_nxt;
  logic [7:0]  ready_r, ready_nxt;
  logic [31:0] nmi_r, nmi_nxt;
  logic [31:0] mark_r, mark_nxt;
  logic [31:0] staged_r, staged_nxt;
  logic [31:0] consumed_r, consumed_nxt;
  logic [3:0]  port_r, port_nxt;

  logic [OFF_W:0] off_x;
  logic [OFF_W:0] mb_rel;
  logic [2:0]     port;
  logic           in_mb;
  logic [7:0]     bumped;
  logic [7:0]     rd;
  logic           adv;
  logic           pulse;

  always_comb begin
    off_x  = {1'b0, item.off};
    mb_rel = off_x - MB_LO;
    port   = mb_rel[PAGE_SHIFT +: 3];
    in_mb  = (off_x >= MB_LO) && (off_x < MB_HI);
    bumped = mem_data + 8'd1;
    if (bumped == 8'd0) begin
      bumped = 8'd1;
    end

    status_nxt   = status_r;
    ready_nxt    = ready_r;
    nmi_nxt      = nmi_r;
    mark_nxt     = mark_r;
    staged_nxt   = staged_r;
    consumed_nxt = consumed_r;
    port_nxt     = port_r;
    rd           = 8'd0;
    adv          = 1'b0;
    pulse        = 1'b0;
    wr_req.en    = 1'b0;
    wr_req.addr  = item.off;
    wr_req.data  = item.data;

    unique case (item.cmd)
      CMD_READ: begin
        priority if (item.off == STATUS_ADDR) begin
          rd = status_r;
        end else if (item.off == READY_ADDR) begin
          nmi_nxt = nmi_r + 32'd1;
          rd      = ready_r;
        end else if (item.off == STROBE_ADDR) begin
          status_nxt = status_r & ~KERNEL_READY_MASK;
        end else if (in_mb) begin
          port_nxt = {1'b0, port};
          // advance only once an nmi has been counted since the commit
          if (port == LAST_PORT && ready_r != 8'd0 && nmi_r != mark_r) begin
            adv = 1'b1;
            if (item.more) begin
              mark_nxt = nmi_r;
            end else begin
              consumed_nxt = consumed_r + 32'd1;
              ready_nxt    = 8'd0;
              pulse        = 1'b1;
            end
          end
        end else begin
          rd = mem_data;
        end
      end
      CMD_WRITE: begin
        wr_req.en = 1'b1;
      end
      CMD_SET_READY: begin
        ready_nxt = item.data;
        if (item.data != 8'd0) begin
          mark_nxt   = nmi_r;
          staged_nxt = staged_r + 32'd1;
        end
      end
      CMD_BUMP: begin
        wr_req.en   = 1'b1;
        wr_req.data = bumped;
      end
      CMD_CLEAR: begin
        wr_req.en   = 1'b1;
        wr_req.data = 8'd0;
      end
      default: begin
      end
    endcase

    wr_req.en = wr_req.en & go;

    result.read_data            = rd;
    result.advance_taken        = adv;
    result.frame_consumed_pulse = pulse;
    result.frames_consumed      = consumed_nxt;
    result.frames_staged        = staged_nxt;
    result.status_now           = status_nxt;
    result.frame_ready_now      = ready_nxt;
    result.last_port            = port_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= KERNEL_READY_MASK;
      ready_r    <= 8'd0;
      nmi_r      <= 32'd0;
      mark_r     <= 32'd0;
      staged_r   <= 32'd0;
      consumed_r <= 32'd0;
      port_r     <= NO_PORT;
    end else if (go) begin
      status_r   <= status_nxt;
      ready_r    <= ready_nxt;
      nmi_r      <= nmi_nxt;
      mark_r     <= mark_nxt;
      staged_r   <= staged_nxt;
      consumed_r <= consumed_nxt;
      port_r     <= port_nxt;
    end
  end

endmodule

[hw/rtl/cart_window_read_side_effects_unit.sv]
// top level of the cartridge window read side effects unit
// depends on cwr_pkg, cwr_window_store and cwr_side_effects
`timescale 1ns / 1ps

// usage
// - input channel in_*: one word per bus read or host command; the command
//   code rides on in_tuser, the address, byte and sub-frame answer on in_tdata
// - result channel out_*: exactly one word per accepted input word, in order
// - pipeline: the accepting edge issues the window read, the next cycle decodes,
//   applies side effects and writes the window back, the result then sits
//   in the output register; out_tvalid rises when the result is loaded
//   there, which waits while a stalled output holds the decode stage
// - throughput: one word per cycle unless out_tready stalls, limited by the
//   single read and single write port of the window memory; a write in the
//   decode cycle is forwarded to a read of the same byte issued in that cycle
// - reset: decoded registers take their reset values at once, then the
//   window is zeroed one byte per cycle, all 65536 bytes, with in_tready low
// - stall: when out_tready is low and a result waits, a word in the decode
//   stage holds and in_tready drops in the same cycle; an empty decode stage
//   still takes one more word; nothing is dropped
module cart_window_read_side_effects_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] address, [23:16] ignored, [31:24] data, [32] more_subframes, [39:33] zero
  input  logic [39:0] in_tdata,
  // [2:0] cmd
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] read_data, [8] advance_taken, [9] frame_consumed_pulse,
  // [41:10] frames_consumed, [73:42] frames_staged, [81:74] status_now,
  // [89:82] frame_ready_now, [93:90] last_port, [95:94] zero
  output logic [95:0] out_tdata
);
  import cwr_pkg::*;

  logic    in_acc;
  logic    s1_go;
  logic    clear_busy;
  logic    s1_vld_r;
  item_t   s1_item_r;
  item_t   in_item;
  logic    out_vld_r, out_vld_nxt;
  result_t out_res_r;
  result_t s1_res;
  wr_req_t wr_req;
  logic [7:0] mem_data;

  always_comb begin
    in_item.cmd  = cmd_t'(in_tuser);
    in_item.off  = in_tdata[OFF_W-1:0];
    in_item.data = in_tdata[31:24];
    in_item.more = in_tdata[32];
  end

  // decode stage moves on when the output register is free or drained
  assign s1_go     = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clear_busy && (!s1_vld_r || s1_go);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (s1_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_go) begin
      out_res_r <= s1_res;
    end
  end

  cwr_window_store u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_acc),
    .rd_addr    (in_item.off),
    .wr_req     (wr_req),
    .rd_data    (mem_data),
    .clear_busy (clear_busy)
  );

  cwr_side_effects u_fx (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (s1_go),
    .item     (s1_item_r),
    .mem_data (mem_data),
    .result   (s1_res),
    .wr_req   (wr_req)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_res_r};

  // no word enters while the window is still being zeroed
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_acc)
    else $error("input accepted during window clear");

  // a closed frame is always an advance and leaves frame-ready at zero
  a_pulse_implies_adv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> out_tdata[8] && (out_tdata[89:82] == 8'd0))
    else $error("frame close without advance or with frame ready set");

  // a full decode stage behind a stalled output blocks the input
  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_vld_r && !out_tready |-> !in_tready)
    else $error("input ready while pipeline is blocked");

  // window writes only come from a stage that is advancing
  a_write_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> s1_go && !clear_busy)
    else $error("window write outside an advancing item");

endmodule
